[src/pixel_splat_accumulator_unit_macros.svh]
// Assertion macros shared by the block's checking code
`ifndef PIXEL_SPLAT_ACCUMULATOR_UNIT_MACROS_SVH
`define PIXEL_SPLAT_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel splat accumulator check failed");

// Next-cycle implication, checked outside reset
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel splat accumulator check failed");

`endif

[src/psa_pkg.sv]
`timescale 1ns / 1ps
package psa_pkg;

    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int FRACTION_BITS = 24;
    localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int DIM_W         = 9;
    localparam int VAL_W         = 64;
    localparam int CNT_W         = 32;

    // Operation codes
    localparam logic [1:0] OP_SPLAT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Combine rules
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_MIN = 2'd1;
    localparam logic [1:0] MODE_MAX = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_AVG    = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_SPLAT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_OOR   = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [63:0] sample_value;
    } t_in;

    typedef struct packed {
        logic [63:0] pixel_value;
        logic        out_of_range;
    } t_out;

    typedef struct packed {
        logic [1:0]        combine_mode;
        logic              averaging;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
        logic clear_busy;
    } t_back_status;

endpackage

[src/psa_front.sv]
`timescale 1ns / 1ps
module psa_front (
    input  psa_pkg::t_in          i_item,
    input  logic                  i_item_valid,
    input  psa_pkg::t_cfg         i_cfg,
    input  psa_pkg::t_back_status i_status,
    input  logic                  i_q_full,
    output logic                  o_item_stall,
    output logic                  o_push,
    output psa_pkg::t_cmd         o_cmd
);
    import psa_pkg::*;

    logic [DIM_W-1:0]    w_clamp;
    logic [DIM_W-1:0]    h_clamp;
    logic                oor;
    logic [ADDR_W+1:0]   addr_full;

    // Clamp the image size to the store
    assign w_clamp = (i_cfg.image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                             : i_cfg.image_width;
    assign h_clamp = (i_cfg.image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                               : i_cfg.image_height;

    assign oor = ({1'b0, i_item.pixel_x} >= w_clamp) || ({1'b0, i_item.pixel_y} >= h_clamp);

    // Row-major address
    assign addr_full = (ADDR_W+2)'(i_item.pixel_y) * (ADDR_W+2)'(w_clamp)
                     + (ADDR_W+2)'(i_item.pixel_x);

    // Hold the input during the start-up sweep or while the queue is full
    assign o_item_stall = i_q_full || i_status.init_busy;

    // Classify; drop unknown operations
    always_comb begin
        o_cmd.addr  = addr_full[ADDR_W-1:0];
        o_cmd.value = i_item.sample_value;
        o_cmd.kind  = CMD_SPLAT;
        o_push      = i_item_valid && !o_item_stall;
        case (i_item.operation)
            OP_SPLAT: o_cmd.kind = oor ? CMD_OOR : CMD_SPLAT;
            OP_READ:  o_cmd.kind = oor ? CMD_OOR : CMD_READ;
            OP_CLEAR: o_cmd.kind = CMD_CLEAR;
            default:  o_push = 1'b0;
        endcase
    end

endmodule

[src/psa_queue.sv]
`timescale 1ns / 1ps
module psa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psa_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output psa_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import psa_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_fill;

    assign o_cmd   = r_slot[r_rd];
    assign o_empty = (r_fill == 2'd0);
    assign o_full  = (r_fill == 2'd2);

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_fill <= r_fill + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[src/psa_div.sv]
`timescale 1ns / 1ps
module psa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [psa_pkg::VAL_W-1:0]     i_dividend,
    input  logic [psa_pkg::CNT_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [psa_pkg::VAL_W-1:0]     o_quotient
);
    import psa_pkg::*;

    logic [CNT_W-1:0]          r_rem;
    logic [VAL_W-1:0]          r_quo;
    logic [CNT_W-1:0]          r_dsr;
    logic [$clog2(VAL_W)-1:0]  r_step;
    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W:0]            shifted;
    logic [CNT_W:0]            diff;
    logic                      fits;

    // One quotient bit per cycle, restoring
    assign shifted = {r_rem, r_quo[VAL_W-1]};
    assign diff    = shifted - {1'b0, r_dsr};
    assign fits    = shifted >= {1'b0, r_dsr};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
                r_quo  <= {r_quo[VAL_W-2:0], fits};
                r_step <= r_step + 1'b1;
                if (&r_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[src/psa_back.sv]
`timescale 1ns / 1ps
module psa_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  psa_pkg::t_cfg         i_cfg,
    input  psa_pkg::t_cmd         i_cmd,
    input  logic                  i_q_empty,
    output logic                  o_pop,
    output psa_pkg::t_back_status o_status,
    output logic                  o_valid,
    output psa_pkg::t_out         o_data,
    input  logic                  i_stall
);
    import psa_pkg::*;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_RD, S_EXEC, S_DIV, S_OUT, S_CLR
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_clr_idx;
    logic              r_neg;
    t_out              r_out;
    logic [VAL_W-1:0]  pix_mem [STORE_DEPTH];
    logic [CNT_W-1:0]  cnt_mem [STORE_DEPTH];
    logic [VAL_W-1:0]  r_pix;
    logic [CNT_W-1:0]  r_cnt;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [VAL_W-1:0]  wd_pix;
    logic [CNT_W-1:0]  wd_cnt;
    logic              clearing;
    logic              v_less;
    logic              p_less;
    logic [CNT_W-1:0]  cnt_inc;
    logic [VAL_W-1:0]  mag;
    logic              div_start;
    logic              div_done;
    logic [VAL_W-1:0]  div_q;

    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign o_valid  = (r_state == S_OUT);
    assign o_data   = r_out;
    assign clearing = (r_state == S_INIT) || (r_state == S_CLR);
    assign o_status = '{init_busy: (r_state == S_INIT), clear_busy: (r_state == S_CLR)};

    // Compare in signed or unsigned order
    always_comb begin
        if (i_cfg.averaging) begin
            v_less = $signed(r_cmd.value) < $signed(r_pix);
            p_less = $signed(r_pix) < $signed(r_cmd.value);
        end else begin
            v_less = r_cmd.value < r_pix;
            p_less = r_pix < r_cmd.value;
        end
    end

    assign cnt_inc = (&r_cnt) ? r_cnt : r_cnt + 1'b1;
    assign mag     = r_pix[VAL_W-1] ? (VAL_W'(0) - r_pix) : r_pix;

    // Form the write for a splat or the clearing sweep
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cmd.addr;
        wd_pix = r_pix;
        wd_cnt = r_cnt;
        if (clearing) begin
            mem_we = 1'b1;
            mem_wa = r_clr_idx;
            wd_pix = '0;
            wd_cnt = '0;
        end else if (r_state == S_EXEC && r_cmd.kind == CMD_SPLAT) begin
            case (i_cfg.combine_mode)
                MODE_ADD: begin
                    mem_we = 1'b1;
                    wd_pix = r_pix + r_cmd.value;
                    wd_cnt = i_cfg.averaging ? cnt_inc : r_cnt;
                end
                MODE_MIN: begin
                    mem_we = 1'b1;
                    wd_pix = v_less ? r_cmd.value : r_pix;
                    wd_cnt = i_cfg.averaging ? CNT_W'(1) : r_cnt;
                end
                MODE_MAX: begin
                    mem_we = 1'b1;
                    wd_pix = p_less ? r_cmd.value : r_pix;
                    wd_cnt = i_cfg.averaging ? CNT_W'(1) : r_cnt;
                end
                default: mem_we = 1'b0;
            endcase
        end
    end

    // Pixel and count stores
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            pix_mem[mem_wa] <= wd_pix;
            cnt_mem[mem_wa] <= wd_cnt;
        end
        r_pix <= pix_mem[r_cmd.addr];
        r_cnt <= cnt_mem[r_cmd.addr];
    end

    assign div_start = (r_state == S_EXEC) && (r_cmd.kind == CMD_READ)
                    && i_cfg.averaging && (r_cnt != '0);

    psa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Sequence one command at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_clr_idx <= '0;
        end else begin
            case (r_state)
                S_INIT, S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (&r_clr_idx) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.kind)
                            CMD_CLEAR: r_state <= S_CLR;
                            CMD_OOR: begin
                                r_out   <= '{pixel_value: '0, out_of_range: 1'b1};
                                r_state <= S_OUT;
                            end
                            default:   r_state <= S_RD;
                        endcase
                    end
                end
                S_RD: r_state <= S_EXEC;
                S_EXEC: begin
                    if (r_cmd.kind == CMD_READ) begin
                        r_neg <= r_pix[VAL_W-1];
                        if (!i_cfg.averaging) begin
                            r_out   <= '{pixel_value: r_pix, out_of_range: 1'b0};
                            r_state <= S_OUT;
                        end else if (r_cnt == '0) begin
                            r_out   <= '{pixel_value: '0, out_of_range: 1'b0};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out   <= '{pixel_value: r_neg ? (VAL_W'(0) - div_q) : div_q,
                                     out_of_range: 1'b0};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[src/pixel_splat_accumulator_unit.sv]
`timescale 1ns / 1ps
// Film accumulation buffer of 256 x 256 pixels, each a 64-bit value plus a
// 32-bit hit count held in on-chip memory. Items enter a two-entry command
// queue and are carried out one at a time by a read-modify-write sequencer
// on the store: a splat passes the read and execute states, an out-of-range
// item goes straight to output and a raw read passes read, execute and output,
// both waiting on the output stall; an averaged read adds a 64-step serial
// divider, and a clear zeroes one store entry per cycle. After reset the same
// sweep zeroes the store and the input is stalled until it ends; configuration
// writes are taken at any time but must only be made while the block is idle.
module pixel_splat_accumulator_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  psa_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output psa_pkg::t_out             o_data,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [psa_pkg::DIM_W-1:0] i_cfg_data
);
    import psa_pkg::*;

    `include "pixel_splat_accumulator_unit_macros.svh"

    t_cfg         r_cfg;
    t_cmd         push_cmd;
    t_cmd         head_cmd;
    logic         push;
    logic         pop;
    logic         q_empty;
    logic         q_full;
    t_back_status status;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{combine_mode: MODE_ADD, averaging: 1'b1,
                       image_width: DIM_W'(256), image_height: DIM_W'(256)};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:   r_cfg.combine_mode <= i_cfg_data[1:0];
                REG_AVG:    r_cfg.averaging    <= i_cfg_data[0];
                REG_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                REG_HEIGHT: r_cfg.image_height <= i_cfg_data;
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    psa_front u_front (
        .i_item       (i_data),
        .i_item_valid (i_valid),
        .i_cfg        (r_cfg),
        .i_status     (status),
        .i_q_full     (q_full),
        .o_item_stall (o_stall),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    psa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    psa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (head_cmd),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_status  (status),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

    `PSA_ASSERT_NOW(a_oor_zero, i_clk, i_rst_n, o_valid && o_data.out_of_range, o_data.pixel_value == '0)
    `PSA_ASSERT_NOW(a_no_take_in_init, i_clk, i_rst_n, status.init_busy, o_stall)
    `PSA_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, q_full, !push)
    `PSA_ASSERT_NEXT(a_init_once, i_clk, i_rst_n, !status.init_busy, !status.init_busy)

endmodule

[verif/tb_pixel_splat_accumulator_unit.sv]
`timescale 1ns / 1ps
module tb_pixel_splat_accumulator_unit;
    import psa_pkg::*;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       i_stall    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_idx  = REG_MODE;
    logic [DIM_W-1:0] i_cfg_data = '0;
    t_in        i_data     = '0;
    logic       o_stall;
    logic       o_valid;
    t_out       o_data;

    // Mirror of the block's state and registers
    bit [63:0]  sum_mem [int];
    bit [31:0]  hits_mem [int];
    logic [1:0] cur_mode;
    bit         cur_avg;
    int         cur_w;
    int         cur_h;

    t_out       pending_pixels [$];
    int         mismatches  = 0;
    int         clears_left = 3;
    bit         quiet       = 1'b0;
    int         stall_left  = 0;

    pixel_splat_accumulator_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int eff_w();
        return (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
    endfunction

    function automatic int eff_h();
        return (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
    endfunction

    function automatic bit [63:0] average_of(bit [63:0] sum, bit [31:0] hits);
        bit        neg;
        bit [63:0] mag;
        bit [63:0] quo;
        if (hits == 0) return 64'd0;
        neg = sum[63];
        mag = neg ? -sum : sum;
        quo = mag / {32'd0, hits};
        return neg ? -quo : quo;
    endfunction

    function automatic bit less_than(bit [63:0] a, bit [63:0] b, bit signed_cmp);
        if (signed_cmp) return $signed(a) < $signed(b);
        return a < b;
    endfunction

    // Apply one accepted transfer to the mirror and queue any result
    function automatic void fold_item(t_in it);
        int        addr;
        bit [63:0] sum;
        bit [31:0] hits;
        t_out      res;
        if (it.operation == OP_CLEAR) begin
            sum_mem.delete();
            hits_mem.delete();
            return;
        end
        if (it.operation != OP_SPLAT && it.operation != OP_READ) return;
        if (int'(it.pixel_x) >= eff_w() || int'(it.pixel_y) >= eff_h()) begin
            res.pixel_value  = 64'd0;
            res.out_of_range = 1'b1;
            pending_pixels.push_back(res);
            return;
        end
        addr = int'(it.pixel_y) * eff_w() + int'(it.pixel_x);
        sum  = sum_mem.exists(addr) ? sum_mem[addr] : 64'd0;
        hits = hits_mem.exists(addr) ? hits_mem[addr] : 32'd0;
        if (it.operation == OP_READ) begin
            res.pixel_value  = cur_avg ? average_of(sum, hits) : sum;
            res.out_of_range = 1'b0;
            pending_pixels.push_back(res);
            return;
        end
        case (cur_mode)
            MODE_ADD: begin
                sum = sum + it.sample_value;
                if (cur_avg && hits != 32'hFFFF_FFFF) hits = hits + 1;
            end
            MODE_MIN: begin
                if (less_than(it.sample_value, sum, cur_avg)) sum = it.sample_value;
                if (cur_avg) hits = 1;
            end
            MODE_MAX: begin
                if (less_than(sum, it.sample_value, cur_avg)) sum = it.sample_value;
                if (cur_avg) hits = 1;
            end
            default: ;
        endcase
        sum_mem[addr]  = sum;
        hits_mem[addr] = hits;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected result", o_data.pixel_value, 64'd0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_data.pixel_value !== want.pixel_value)
                    report_mismatch("pixel_value", o_data.pixel_value, want.pixel_value);
                if (o_data.out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", o_data.out_of_range, want.out_of_range);
            end
            stall_left = quiet ? 0 : $urandom_range(0, 15);
        end
    end

    // Hold off the result side for the drawn number of cycles
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] x, logic [7:0] y, logic [63:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = '{operation: op, pixel_x: x, pixel_y: y, sample_value: v};
        do @(posedge i_clk); while (o_stall);
        fold_item(i_data);
    endtask

    // Finish with a read so that any clear has ended, then drain
    task automatic settle();
        send_item(OP_READ, 8'd0, 8'd0, 64'd0);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value[DIM_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_MODE:   cur_mode = value[1:0];
            REG_AVG:    cur_avg  = value[0];
            REG_WIDTH:  cur_w    = value & 'h1FF;
            default:    cur_h    = value & 'h1FF;
        endcase
    endtask

    task automatic set_config(int mode, int avg, int w, int h);
        write_reg(REG_MODE, mode);
        write_reg(REG_AVG, avg);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // Reset values: averaging add over the full image, negative averages
    task automatic test_reset_defaults();
        send_item(OP_READ, 8'd255, 8'd255, 64'd0);
        send_item(OP_SPLAT, 8'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_SPLAT, 8'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFD);
        send_item(OP_READ, 8'd0, 8'd0, 64'd0);
        send_item(OP_SPLAT, 8'd255, 8'd255, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_SPLAT, 8'd255, 8'd255, 64'h8000_0000_0000_0000);
        send_item(OP_SPLAT, 8'd255, 8'd255, 64'd7);
        send_item(OP_READ, 8'd255, 8'd255, 64'd0);
        send_item(2'd3, 8'd1, 8'd1, 64'd5);
        settle();
    endtask

    // Min and max in both arithmetic modes, and the unused rule
    task automatic test_combine_rules();
        set_config(MODE_MIN, 1, 256, 256);
        send_item(OP_SPLAT, 8'd3, 8'd4, 64'hFFFF_FFFF_0000_0000);
        send_item(OP_READ, 8'd3, 8'd4, 64'd0);
        settle();
        write_reg(REG_MODE, MODE_MAX);
        send_item(OP_SPLAT, 8'd3, 8'd4, 64'h0000_0001_0000_0000);
        send_item(OP_READ, 8'd3, 8'd4, 64'd0);
        settle();
        set_config(MODE_MAX, 0, 256, 256);
        send_item(OP_SPLAT, 8'd9, 8'd2, 64'h8000_0000_0000_0001);
        send_item(OP_READ, 8'd9, 8'd2, 64'd0);
        settle();
        write_reg(REG_MODE, MODE_MIN);
        send_item(OP_SPLAT, 8'd9, 8'd2, 64'h7000_0000_0000_0000);
        send_item(OP_READ, 8'd9, 8'd2, 64'd0);
        settle();
        write_reg(REG_MODE, 3);
        send_item(OP_SPLAT, 8'd9, 8'd2, 64'd1);
        send_item(OP_READ, 8'd9, 8'd2, 64'd0);
        settle();
    endtask

    // Zero, small and over-size dimensions, out-of-range coordinates
    task automatic test_dimensions();
        set_config(MODE_ADD, 0, 0, 5);
        send_item(OP_SPLAT, 8'd0, 8'd0, 64'd1);
        send_item(OP_READ, 8'd0, 8'd0, 64'd0);
        settle();
        set_config(MODE_ADD, 0, 511, 1);
        send_item(OP_SPLAT, 8'd255, 8'd0, 64'd11);
        send_item(OP_READ, 8'd255, 8'd0, 64'd0);
        send_item(OP_READ, 8'd0, 8'd1, 64'd0);
        settle();
        set_config(MODE_ADD, 1, 1, 300);
        send_item(OP_SPLAT, 8'd1, 8'd0, 64'd3);
        send_item(OP_SPLAT, 8'd0, 8'd255, 64'd3);
        send_item(OP_READ, 8'd0, 8'd255, 64'd0);
        settle();
    endtask

    task automatic test_clear();
        send_item(OP_CLEAR, 8'd0, 8'd0, 64'd0);
        send_item(OP_READ, 8'd0, 8'd255, 64'd0);
        settle();
    endtask

    // Random phases over several settings; small images give many hits
    task automatic test_random(int phases, int per_phase);
        int        w;
        int        h;
        int        pick;
        logic [1:0] op;
        logic [7:0] x;
        logic [7:0] y;
        logic [63:0] v;
        for (int p = 0; p < phases; p++) begin
            case (p % 4)
                0: begin w = 256; h = 256; end
                1: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
                2: begin w = $urandom_range(0, 511); h = $urandom_range(1, 4); end
                default: begin w = $urandom_range(1, 20); h = $urandom_range(0, 20); end
            endcase
            set_config($urandom_range(0, 3), $urandom_range(0, 1), w, h);
            quiet = (p % 3 == 2);
            for (int i = 0; i < per_phase; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)      op = OP_SPLAT;
                else if (pick < 97) op = OP_READ;
                else if (pick < 99) op = 2'd3;
                else if (clears_left > 0) begin
                    op = OP_CLEAR;
                    clears_left--;
                end else op = OP_READ;
                if ($urandom_range(0, 7) == 0 || eff_w() >= 255) begin
                    x = $urandom_range(0, 255);
                end else begin
                    x = $urandom_range(0, eff_w() + 1);
                end
                if ($urandom_range(0, 7) == 0 || eff_h() >= 255) begin
                    y = $urandom_range(0, 255);
                end else begin
                    y = $urandom_range(0, eff_h() + 1);
                end
                v = {$urandom, $urandom};
                if ($urandom_range(0, 1) == 1) v = {{40{v[23]}}, v[23:0]};
                send_item(op, x, y, v);
                if (i == per_phase / 2) begin
                    // Let everything drain before going on
                    @(negedge i_clk);
                    i_valid = 1'b0;
                    while (pending_pixels.size() != 0) @(posedge i_clk);
                end
            end
            quiet = 1'b0;
            settle();
        end
    endtask

    initial begin
        cur_mode = MODE_ADD;
        cur_avg  = 1'b1;
        cur_w    = 256;
        cur_h    = 256;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_combine_rules();
        test_dimensions();
        test_clear();
        test_random(8, 240);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
